FILE: rtl/core/icwc_pkg.sv
// Shared types, codes and helpers for the RGBA wrap-and-clamp convolution block.
`timescale 1ns / 1ps
`default_nettype none
package icwc_pkg;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_REQ   = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_RADIUS  = 3'd2;
    localparam logic [2:0] CFG_COEF_M2 = 3'd3;
    localparam logic [2:0] CFG_COEF_M1 = 3'd4;
    localparam logic [2:0] CFG_COEF_0  = 3'd5;
    localparam logic [2:0] CFG_COEF_P1 = 3'd6;
    localparam logic [2:0] CFG_COEF_P2 = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int POS_W      = 6;
    localparam int CW         = 7;   // size / wrapped coordinate width
    localparam int CH_W       = 8;
    localparam int COEF_W     = 12;
    localparam int PROD_W     = 20;
    localparam int SUM_W      = 16;
    localparam int TAP_W      = 3;   // tap index 0..4

    localparam logic [CW-1:0]         RST_WIDTH  = 7'd64;
    localparam logic [CW-1:0]         RST_HEIGHT = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_0 = 60'd17179869184;
    localparam logic [CH_W-1:0]       CH_MAX     = 8'd255;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAPS,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_pix;
        logic start;
        logic tap;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic last_tap;
        logic busy;
    } t_dp_stat;

    // Pick the Q1.10 coefficient of one row out of a packed column word.
    function automatic logic signed [COEF_W-1:0] coef_pick(
        input logic [CFG_DATA_W-1:0] col,
        input logic [TAP_W-1:0]      row
    );
        logic signed [COEF_W-1:0] k;
        case (row)
            3'd0:    k = col[11:0];
            3'd1:    k = col[23:12];
            3'd2:    k = col[35:24];
            3'd3:    k = col[47:36];
            3'd4:    k = col[59:48];
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/image_convolution_wrap_clamp_unit.sv
// Top level of the RGBA 2D convolution block with toroidal wrap and channel clamping.
// Usage:
//  - Input channel (i_valid / o_stall): one transfer carries an item. i_op = write
//    stores the RGBA pixel at (i_pos_x, i_pos_y); i_op = request asks for the
//    filtered pixel at that position.
//  - Output channel (o_valid / i_stall): one transfer per request, none per write.
//  - Config port: i_cfg_we writes register i_cfg_idx (width, height, radius,
//    five coefficient columns) from i_cfg_data; change it only while idle.
//  - A write leaves the input free. A request walks (2r+1)^2 taps, one
//    pixel-store read per cycle on the single read port, then drains a
//    two-stage multiply and accumulate pipe, with the input stalled until
//    its result is loaded into the output register.
//  - Out-of-size requests skip the taps and return zeros with o_out_of_range set.
//  - The result sits in an output register; a write can be taken while it waits.
//    A second finished request waits until that register is drained.
//  - Reset restores the register defaults (64x64, radius 0, identity center) and
//    idles the controller. The pixel store is not cleared; reading an unwritten
//    pixel gives unspecified data.
`timescale 1ns / 1ps
`default_nettype none
module image_convolution_wrap_clamp_unit
    import icwc_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 2
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire                   i_op,
    input  wire  [POS_W-1:0]      i_pos_x,
    input  wire  [POS_W-1:0]      i_pos_y,
    input  wire  [CH_W-1:0]       i_red_in,
    input  wire  [CH_W-1:0]       i_green_in,
    input  wire  [CH_W-1:0]       i_blue_in,
    input  wire  [CH_W-1:0]       i_alpha_in,
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic [POS_W-1:0]      o_out_x,
    output logic [POS_W-1:0]      o_out_y,
    output logic [CH_W-1:0]       o_red_out,
    output logic [CH_W-1:0]       o_green_out,
    output logic [CH_W-1:0]       o_blue_out,
    output logic [CH_W-1:0]       o_alpha_out,
    output logic                  o_out_of_range,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing: accept, tap walk, pipe drain, output load
    icwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // storage and arithmetic
    icwc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_alpha_in     (i_alpha_in),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_alpha_out    (o_alpha_out),
        .o_out_of_range (o_out_of_range)
    );

endmodule
`default_nettype wire

FILE: rtl/core/icwc_ctrl.sv
// Controller state machine: accepts items, sequences taps, loads the output register.
`timescale 1ns / 1ps
`default_nettype none
module icwc_ctrl
    import icwc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    input  wire      i_op,
    output logic     o_stall,
    output logic     o_valid,
    input  wire      i_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_op == OP_REQ) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_TAPS;
                    end else begin
                        o_cmd.wr_pix = 1'b1;
                    end
                end
            end
            S_TAPS: begin
                if (!i_stat.in_range) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.tap = 1'b1;
                    if (i_stat.last_tap) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // output register holds a result until its transfer
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_valid = r_out_vld;

endmodule
`default_nettype wire

FILE: rtl/core/icwc_dp.sv
// Datapath: config registers, pixel store, tap address walk, MAC pipeline, output register.
`timescale 1ns / 1ps
`default_nettype none
module icwc_dp
    import icwc_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 2
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  wire  [POS_W-1:0]      i_pos_x,
    input  wire  [POS_W-1:0]      i_pos_y,
    input  wire  [CH_W-1:0]       i_red_in,
    input  wire  [CH_W-1:0]       i_green_in,
    input  wire  [CH_W-1:0]       i_blue_in,
    input  wire  [CH_W-1:0]       i_alpha_in,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    output logic [POS_W-1:0]      o_out_x,
    output logic [POS_W-1:0]      o_out_y,
    output logic [CH_W-1:0]       o_red_out,
    output logic [CH_W-1:0]       o_green_out,
    output logic [CH_W-1:0]       o_blue_out,
    output logic [CH_W-1:0]       o_alpha_out,
    output logic                  o_out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int AWX   = AW + CW;
    localparam int R_LIM = (MAX_RADIUS < 2) ? MAX_RADIUS : 2;

    // config
    logic [CW-1:0]         r_width, r_height;
    logic [1:0]            r_radius;
    logic [CFG_DATA_W-1:0] r_coef [5];

    // request walk
    logic [POS_W-1:0] r_px, r_py;
    logic             r_in_range;
    logic [CW-1:0]    r_nx, r_ny, r_ny0;
    logic [TAP_W-1:0] r_dx_i, r_dy_i;

    // MAC pipeline
    logic [31:0]                r_mem [DEPTH];
    logic [31:0]                r_rd_data;
    logic signed [COEF_W-1:0]   r_k;
    logic                       r_v1, r_v2;
    logic signed [PROD_W-1:0]   r_prod [4];
    logic signed [SUM_W-1:0]    r_sum [4];
    logic signed [SUM_W-1:0]    n_sum [4];

    logic [CW-1:0]    w_eff, h_eff;
    logic [1:0]       r_eff;
    logic [TAP_W-1:0] span, col, row;
    logic             wr_ok, req_in_range;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic signed [COEF_W-1:0] tap_k;

    function automatic logic [CW-1:0] wrap_lo(
        input logic [POS_W-1:0] pos,
        input logic [1:0]       r,
        input logic [CW-1:0]    size
    );
        logic [CW:0] t;
        t = {2'b00, pos} - {{(CW-1){1'b0}}, r};
        if (t[CW]) begin
            t = t + {1'b0, size};
        end
        return t[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] inc_wrap(
        input logic [CW-1:0] v,
        input logic [CW-1:0] size
    );
        logic [CW:0] s;
        s = {1'b0, v} + {{CW{1'b0}}, 1'b1};
        return (s == {1'b0, size}) ? '0 : s[CW-1:0];
    endfunction

    // exact per-tap step: trunc toward zero of (sum*1024 + prod) / 1024
    function automatic logic signed [SUM_W-1:0] acc_step(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [SUM_W+10:0] t;
        logic signed [SUM_W:0]    q;
        t = {s[SUM_W-1], s, 10'b0} + (SUM_W+11)'(p);
        q = t[SUM_W+10:10];
        if (t[SUM_W+10] && (t[9:0] != '0)) begin
            q = q + (SUM_W+1)'(1);
        end
        return q[SUM_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [SUM_W-1:0] s);
        if (s < 0) begin
            return '0;
        end else if (s > $signed({{(SUM_W-CH_W){1'b0}}, CH_MAX})) begin
            return CH_MAX;
        end
        return s[CH_W-1:0];
    endfunction

    // effective sizes and radius, saturated
    always_comb begin
        if (r_width < 7'd4) begin
            w_eff = 7'd4;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < 7'd4) begin
            h_eff = 7'd4;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h_eff = CW'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
        r_eff = (32'(r_radius) > R_LIM) ? 2'(R_LIM) : r_radius;
    end

    assign span         = {r_eff, 1'b0};
    assign col          = r_dx_i + 3'd2 - {1'b0, r_eff};
    assign row          = r_dy_i + 3'd2 - {1'b0, r_eff};
    assign tap_k        = coef_pick(r_coef[col], row);
    assign req_in_range = ({1'b0, i_pos_x} < w_eff) && ({1'b0, i_pos_y} < h_eff);
    assign wr_ok        = (32'(i_pos_x) < MAX_WIDTH) && (32'(i_pos_y) < MAX_HEIGHT);
    assign wr_addr = AW'(AWX'(i_pos_y) * AWX'(MAX_WIDTH) + AWX'(i_pos_x));
    assign rd_addr = AW'(AWX'(r_ny) * AWX'(MAX_WIDTH) + AWX'(r_nx));

    assign o_stat.in_range = r_in_range;
    assign o_stat.last_tap = (r_dx_i == span) && (r_dy_i == span);
    assign o_stat.busy     = r_v1 | r_v2;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
            r_radius  <= 2'd0;
            r_coef[0] <= '0;
            r_coef[1] <= '0;
            r_coef[2] <= RST_COEF_0;
            r_coef[3] <= '0;
            r_coef[4] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:   r_width   <= i_cfg_data[CW-1:0];
                CFG_HEIGHT:  r_height  <= i_cfg_data[CW-1:0];
                CFG_RADIUS:  r_radius  <= i_cfg_data[1:0];
                CFG_COEF_M2: r_coef[0] <= i_cfg_data;
                CFG_COEF_M1: r_coef[1] <= i_cfg_data;
                CFG_COEF_0:  r_coef[2] <= i_cfg_data;
                CFG_COEF_P1: r_coef[3] <= i_cfg_data;
                CFG_COEF_P2: r_coef[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pixel store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pix && wr_ok) begin
            r_mem[wr_addr] <= {i_alpha_in, i_blue_in, i_green_in, i_red_in};
        end
        if (i_cmd.tap) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // neighbor walk: dx outer, dy inner, coordinates wrap incrementally
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px       <= i_pos_x;
            r_py       <= i_pos_y;
            r_in_range <= req_in_range;
            r_nx       <= wrap_lo(i_pos_x, r_eff, w_eff);
            r_ny       <= wrap_lo(i_pos_y, r_eff, h_eff);
            r_ny0      <= wrap_lo(i_pos_y, r_eff, h_eff);
            r_dx_i     <= '0;
            r_dy_i     <= '0;
        end else if (i_cmd.tap) begin
            if (r_dy_i == span) begin
                r_dy_i <= '0;
                r_ny   <= r_ny0;
                r_dx_i <= r_dx_i + 3'd1;
                r_nx   <= inc_wrap(r_nx, w_eff);
            end else begin
                r_dy_i <= r_dy_i + 3'd1;
                r_ny   <= inc_wrap(r_ny, h_eff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            n_sum[ch] = acc_step(r_sum[ch], r_prod[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap) begin
            r_k <= tap_k;
        end
        for (int ch = 0; ch < 4; ch++) begin
            if (r_v1) begin
                r_prod[ch] <= PROD_W'($signed({1'b0, r_rd_data[8*ch +: 8]}) * r_k);
            end
            if (i_cmd.start) begin
                r_sum[ch] <= '0;
            end else if (r_v2) begin
                r_sum[ch] <= n_sum[ch];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_x        <= r_px;
            o_out_y        <= r_py;
            o_out_of_range <= !r_in_range;
            o_red_out      <= r_in_range ? clamp_ch(r_sum[0]) : '0;
            o_green_out    <= r_in_range ? clamp_ch(r_sum[1]) : '0;
            o_blue_out     <= r_in_range ? clamp_ch(r_sum[2]) : '0;
            o_alpha_out    <= r_in_range ? clamp_ch(r_sum[3]) : '0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/icwc_checker.sv
// Port-level checker for the convolution block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module icwc_checker
    import icwc_pkg::*;
(
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_valid,
    input wire             o_stall,
    input wire             i_op,
    input wire             o_valid,
    input wire             i_stall,
    input wire [CH_W-1:0]  o_red_out,
    input wire [CH_W-1:0]  o_green_out,
    input wire [CH_W-1:0]  o_blue_out,
    input wire [CH_W-1:0]  o_alpha_out,
    input wire             o_out_of_range
);

    // a pending result is not withdrawn
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // out-of-size result carries zero channels
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> (o_red_out == '0) && (o_green_out == '0)
            && (o_blue_out == '0) && (o_alpha_out == '0))
        else $error("out-of-range result with nonzero channels");

    // a request occupies the block after its transfer
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_REQ) |=> o_stall)
        else $error("input taken right after a request");

    // a new result only appears while a request is being worked
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared from idle");

endmodule

bind image_convolution_wrap_clamp_unit icwc_checker u_icwc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_op           (i_op),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_red_out      (o_red_out),
    .o_green_out    (o_green_out),
    .o_blue_out     (o_blue_out),
    .o_alpha_out    (o_alpha_out),
    .o_out_of_range (o_out_of_range)
);
`default_nettype wire

FILE: test/image_convolution_wrap_clamp_unit_tb.sv
// Self-checking testbench for the RGBA wrap-and-clamp convolution unit.
`timescale 1ns / 1ps
module image_convolution_wrap_clamp_unit_tb;
    import icwc_pkg::*;

    localparam int IMG_MAX_W     = 64;
    localparam int IMG_MAX_H     = 64;
    localparam int KER_MAX_R     = 2;
    localparam int STORE_SIZE    = IMG_MAX_W * IMG_MAX_H;
    localparam int CLK_HALF      = 6;      // 12 ns period
    localparam int RESET_CYCLES  = 9;
    localparam int QUIET_LIMIT   = 3000;   // cycles without any transfer
    localparam int SETTLE_CYCLES = 40;     // > worst request latency
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int MAX_REPORTS   = 10;
    localparam int CHUNK_ITEMS   = 90;     // items per configuration, fill writes included

    // One filtered pixel as the output channel presents it.
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic             oor;
    } t_pix_result;

    // Ways of filling the coefficient columns.
    typedef enum int {
        COEF_IDENT,
        COEF_BOX,
        COEF_MILD,
        COEF_FULL,
        COEF_MAXPOS,
        COEF_MAXNEG,
        COEF_TINYNEG,
        COEF_ZERO
    } t_coef_style;

    // ---------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ---------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic                  i_op       = OP_WRITE;
    logic [POS_W-1:0]      i_pos_x    = '0;
    logic [POS_W-1:0]      i_pos_y    = '0;
    logic [CH_W-1:0]       i_red_in   = '0;
    logic [CH_W-1:0]       i_green_in = '0;
    logic [CH_W-1:0]       i_blue_in  = '0;
    logic [CH_W-1:0]       i_alpha_in = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic [POS_W-1:0]      o_out_x;
    logic [POS_W-1:0]      o_out_y;
    logic [CH_W-1:0]       o_red_out;
    logic [CH_W-1:0]       o_green_out;
    logic [CH_W-1:0]       o_blue_out;
    logic [CH_W-1:0]       o_alpha_out;
    logic                  o_out_of_range;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    image_convolution_wrap_clamp_unit #(
        .MAX_WIDTH  (IMG_MAX_W),
        .MAX_HEIGHT (IMG_MAX_H),
        .MAX_RADIUS (KER_MAX_R)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_alpha_in     (i_alpha_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_alpha_out    (o_alpha_out),
        .o_out_of_range (o_out_of_range),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor state: shadow image, shadow registers, pending results
    // ---------------------------------------------------------------
    logic [31:0]           img_shadow  [STORE_SIZE];
    bit                    img_written [STORE_SIZE];
    logic [CW-1:0]         cfg_width;
    logic [CW-1:0]         cfg_height;
    logic [1:0]            cfg_radius;
    logic [CFG_DATA_W-1:0] cfg_coef    [5];
    t_pix_result           pending_pixels [$];

    // Idle profile of both sides, in percent of cycles.
    int src_idle_pct  = 14;
    int sink_idle_pct = 86;
    int hold_left     = 0;   // receiver hold-off, counted down by the stall process

    // Run statistics
    int n_writes     = 0;
    int n_requests   = 0;
    int n_results    = 0;
    int n_oor        = 0;
    int n_cfg_writes = 0;
    int err_cnt      = 0;
    int quiet_cycles = 0;

    t_pix_result got_px;
    t_pix_result exp_px;

    // ---------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    // Sizes and radius after saturation, as the block uses them.
    function automatic int eff_width();
        int w;
        w = cfg_width;
        if (w < 4) w = 4;
        if (w > IMG_MAX_W) w = IMG_MAX_W;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = cfg_height;
        if (h < 4) h = 4;
        if (h > IMG_MAX_H) h = IMG_MAX_H;
        return h;
    endfunction

    function automatic int eff_radius();
        int r;
        r = cfg_radius;
        if (r > KER_MAX_R) r = KER_MAX_R;
        if (r > 2) r = 2;
        return r;
    endfunction

    // Toroidal wrap; size >= 4 > radius, so one correction is enough.
    function automatic int wrap_pos(int v, int size);
        if (v < 0) v += size;
        if (v >= size) v -= size;
        return v;
    endfunction

    function automatic logic [CH_W-1:0] clamp_ch(longint s);
        if (s < 0) return '0;
        if (s > longint'(CH_MAX)) return CH_MAX;
        return CH_W'(s);
    endfunction

    // Filtered pixel at (px, py) from the shadow image and registers.
    function automatic t_pix_result filter_pixel(int px, int py);
        t_pix_result      res;
        int               w, h, r, dx, dy, nx, ny, ch;
        longint           acc [4];
        longint           k, c;
        logic [31:0]      pix;
        logic [COEF_W-1:0] raw;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        res   = '0;
        res.x = POS_W'(px);
        res.y = POS_W'(py);
        if (px >= w || py >= h) begin
            res.oor = 1'b1;
            return res;
        end
        for (ch = 0; ch < 4; ch++) acc[ch] = 0;
        // dx outer, dy inner; the running sum truncates toward zero after each tap
        for (dx = -r; dx <= r; dx++) begin
            nx = wrap_pos(px + dx, w);
            for (dy = -r; dy <= r; dy++) begin
                ny  = wrap_pos(py + dy, h);
                pix = img_shadow[ny * IMG_MAX_W + nx];
                raw = cfg_coef[dx + 2][COEF_W * (dy + 2) +: COEF_W];
                k   = longint'($signed(raw));
                for (ch = 0; ch < 4; ch++) begin
                    c       = longint'(pix[CH_W * ch +: CH_W]);
                    acc[ch] = (acc[ch] * 1024 + c * k) / 1024;
                end
            end
        end
        res.red   = clamp_ch(acc[0]);
        res.green = clamp_ch(acc[1]);
        res.blue  = clamp_ch(acc[2]);
        res.alpha = clamp_ch(acc[3]);
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] make_coef_col(t_coef_style style, int col);
        logic [CFG_DATA_W-1:0] word;
        logic [COEF_W-1:0]     k;
        int                    row;
        word = '0;
        for (row = 0; row < 5; row++) begin
            case (style)
                COEF_IDENT:   k = (col == 2 && row == 2) ? 12'h400 : 12'h000;
                COEF_BOX:     k = 12'd41;                       // about 1/25
                COEF_MILD:    k = COEF_W'(int'($urandom_range(300)) - 60);
                COEF_FULL:    k = COEF_W'($urandom());
                COEF_MAXPOS:  k = 12'h7FF;
                COEF_MAXNEG:  k = 12'h800;
                COEF_TINYNEG: k = 12'hFFF;                      // -1/1024
                default:      k = 12'h000;
            endcase
            word[row * COEF_W +: COEF_W] = k;
        end
        return word;
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random stall, or a counted hold-off when requested
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < sink_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker: each output transfer against the oldest expectation
    // ---------------------------------------------------------------
    task automatic note_failure(string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_px = '{o_out_x, o_out_y, o_red_out, o_green_out, o_blue_out,
                       o_alpha_out, o_out_of_range};
            n_results++;
            if (got_px.oor) n_oor++;
            if (pending_pixels.size() == 0) begin
                note_failure($sformatf("unexpected result (%0d,%0d) %h %h %h %h oor %b",
                    got_px.x, got_px.y, got_px.red, got_px.green, got_px.blue,
                    got_px.alpha, got_px.oor));
            end else begin
                exp_px = pending_pixels.pop_front();
                if (got_px.x !== exp_px.x || got_px.y !== exp_px.y ||
                    got_px.red !== exp_px.red || got_px.green !== exp_px.green ||
                    got_px.blue !== exp_px.blue || got_px.alpha !== exp_px.alpha ||
                    got_px.oor !== exp_px.oor) begin
                    note_failure($sformatf({"exp (%0d,%0d) rgba %h %h %h %h oor %b",
                        " / got (%0d,%0d) rgba %h %h %h %h oor %b"},
                        exp_px.x, exp_px.y, exp_px.red, exp_px.green, exp_px.blue,
                        exp_px.alpha, exp_px.oor, got_px.x, got_px.y, got_px.red,
                        got_px.green, got_px.blue, got_px.alpha, got_px.oor));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: ends the run after too many cycles with no transfer
    // ---------------------------------------------------------------
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: %0d cycles without any transfer, %0d results pending",
                 QUIET_LIMIT, pending_pixels.size());
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // One input transfer. Starts at the next falling edge, returns at the
    // rising edge that took the item; the payload is held while stalled.
    task automatic send_item(logic op, int x, int y, logic [31:0] rgba);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_pos_x    <= POS_W'(x);
        i_pos_y    <= POS_W'(y);
        i_red_in   <= rgba[7:0];
        i_green_in <= rgba[15:8];
        i_blue_in  <= rgba[23:16];
        i_alpha_in <= rgba[31:24];
        do @(posedge i_clk); while (o_stall);
        if (op == OP_WRITE) begin
            img_shadow[y * IMG_MAX_W + x]  = rgba;
            img_written[y * IMG_MAX_W + x] = 1'b1;
            n_writes++;
        end else begin
            pending_pixels = {pending_pixels, filter_pixel(x, y)};
            n_requests++;
        end
    endtask

    // Request a pixel; any never-written neighbor is written first so the
    // block never reads undefined store contents.
    task automatic request_pixel(int x, int y);
        int w, h, r, dx, dy, nx, ny;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        if (x < w && y < h) begin
            for (dx = -r; dx <= r; dx++) begin
                for (dy = -r; dy <= r; dy++) begin
                    nx = wrap_pos(x + dx, w);
                    ny = wrap_pos(y + dy, h);
                    if (!img_written[ny * IMG_MAX_W + nx])
                        send_item(OP_WRITE, nx, ny, $urandom());
                end
            end
        end
        send_item(OP_REQ, x, y, $urandom());
    endtask

    // Drop valid, wait until every result is back, then let the pipe go quiet.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH:   cfg_width  = data[CW-1:0];
            CFG_HEIGHT:  cfg_height = data[CW-1:0];
            CFG_RADIUS:  cfg_radius = data[1:0];
            CFG_COEF_M2, CFG_COEF_M1, CFG_COEF_0, CFG_COEF_P1, CFG_COEF_P2:
                cfg_coef[idx - CFG_COEF_M2] = data;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Rewrite every register while idle. Unused upper bits carry junk.
    task automatic set_config(int w, int h, int r, t_coef_style style);
        logic [CFG_DATA_W-1:0] junk;
        int                    col;
        wait_idle();
        junk = CFG_DATA_W'({$urandom(), $urandom()});
        cfg_write(CFG_WIDTH, {junk[CFG_DATA_W-1:CW], CW'(w)});
        junk = CFG_DATA_W'({$urandom(), $urandom()});
        cfg_write(CFG_HEIGHT, {junk[CFG_DATA_W-1:CW], CW'(h)});
        junk = CFG_DATA_W'({$urandom(), $urandom()});
        cfg_write(CFG_RADIUS, {junk[CFG_DATA_W-1:2], 2'(r)});
        for (col = 0; col < 5; col++)
            cfg_write(CFG_COEF_M2 + CFG_IDX_W'(col), make_coef_col(style, col));
    endtask

    // Size register value: mostly legal, with both extremes and saturating codes.
    function automatic int pick_size();
        case ($urandom_range(9))
            0:       return 4;
            1:       return 64;
            2:       return $urandom_range(3);
            3:       return $urandom_range(127, 65);
            default: return $urandom_range(64, 4);
        endcase
    endfunction

    function automatic t_coef_style pick_style();
        case ($urandom_range(9))
            0, 1, 2, 3: return COEF_MILD;
            4:          return COEF_BOX;
            5:          return COEF_FULL;
            6:          return COEF_IDENT;
            7:          return ($urandom_range(1) != 0) ? COEF_MAXPOS : COEF_MAXNEG;
            default:    return ($urandom_range(1) != 0) ? COEF_TINYNEG : COEF_ZERO;
        endcase
    endfunction

    // Random mix: writes anywhere in the store, requests mostly inside the image.
    // Fill writes ahead of a request count toward the item budget.
    task automatic run_random(int n_items);
        int x, y, w, h, stop_at;
        stop_at = n_writes + n_requests + n_items;
        while (n_writes + n_requests < stop_at) begin
            w = eff_width();
            h = eff_height();
            if ($urandom_range(99) < 40) begin
                if ($urandom_range(1) != 0) begin
                    x = $urandom_range(w - 1);
                    y = $urandom_range(h - 1);
                end else begin
                    x = $urandom_range(IMG_MAX_W - 1);
                    y = $urandom_range(IMG_MAX_H - 1);
                end
                send_item(OP_WRITE, x, y, $urandom());
            end else begin
                if ($urandom_range(99) < 85) begin
                    x = $urandom_range(w - 1);
                    y = $urandom_range(h - 1);
                end else begin
                    x = $urandom_range(IMG_MAX_W - 1);
                    y = $urandom_range(IMG_MAX_H - 1);
                end
                request_pixel(x, y);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Test tasks
    // ---------------------------------------------------------------
    // Register defaults: 64x64, radius 0, identity center -> pixel passes through.
    task automatic test_reset_defaults();
        send_item(OP_WRITE, 0, 0, 32'h0000_0000);
        send_item(OP_WRITE, IMG_MAX_W - 1, IMG_MAX_H - 1, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 21, 42, 32'hA55A_3CC3);
        request_pixel(0, 0);
        request_pixel(IMG_MAX_W - 1, IMG_MAX_H - 1);
        request_pixel(21, 42);
    endtask

    // Requests beyond the configured size come back as zeros with the flag.
    task automatic test_out_of_range();
        set_config(4, 4, 0, COEF_IDENT);
        request_pixel(4, 0);
        request_pixel(0, 4);
        request_pixel(IMG_MAX_W - 1, IMG_MAX_H - 1);
        request_pixel(3, 3);
    endtask

    // Radius 2 on the smallest image and on a 7x5 image: taps wrap at the corners.
    task automatic test_wrap_corners();
        set_config(4, 4, 2, COEF_MILD);
        request_pixel(0, 0);
        request_pixel(3, 3);
        set_config(7, 5, 2, COEF_BOX);
        request_pixel(6, 4);
        request_pixel(0, 4);
    endtask

    // Saturation at both ends and truncation of small negative taps.
    task automatic test_clamp();
        set_config(4, 4, 1, COEF_MAXPOS);
        send_item(OP_WRITE, 1, 1, 32'hFFFF_FFFF);
        request_pixel(1, 1);
        set_config(4, 4, 1, COEF_MAXNEG);
        request_pixel(2, 2);
        set_config(4, 4, 1, COEF_TINYNEG);
        request_pixel(1, 2);
        set_config(4, 4, 1, COEF_ZERO);
        request_pixel(0, 0);
    endtask

    // Register codes beyond the legal range saturate.
    task automatic test_saturated_config();
        set_config(0, 127, 3, COEF_BOX);      // 4 x 64, radius 2
        request_pixel(3, IMG_MAX_H - 1);
        request_pixel(4, 10);
        set_config(127, 3, 3, COEF_MILD);     // 64 x 4, radius 2
        request_pixel(IMG_MAX_W - 1, 3);
        request_pixel(10, 4);
    endtask

    // Long receiver hold-off while the sender keeps offering requests: the
    // output register and the finished request behind it back up the input.
    task automatic test_backpressure();
        int saved_src, i;
        set_config(64, 64, 2, COEF_MILD);
        saved_src    = src_idle_pct;
        src_idle_pct = 0;
        hold_left    = HOLD_CYCLES;
        for (i = 0; i < 12; i++)
            request_pixel($urandom_range(IMG_MAX_W - 1), $urandom_range(IMG_MAX_H - 1));
        src_idle_pct = saved_src;
        wait_idle();
    endtask

    // One idle profile, several random configurations.
    task automatic test_random_phase(int src_pct, int sink_pct);
        int chunk;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (chunk = 0; chunk < 4; chunk++) begin
            set_config(pick_size(), pick_size(), $urandom_range(3), pick_style());
            run_random(CHUNK_ITEMS);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        cfg_width   = RST_WIDTH;
        cfg_height  = RST_HEIGHT;
        cfg_radius  = '0;
        cfg_coef[0] = '0;
        cfg_coef[1] = '0;
        cfg_coef[2] = RST_COEF_0;
        cfg_coef[3] = '0;
        cfg_coef[4] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_out_of_range();
        test_wrap_corners();
        test_clamp();
        test_saturated_config();
        test_backpressure();

        test_random_phase(14, 86);
        test_random_phase(86, 14);
        test_random_phase(0, 0);

        wait_idle();
        if (pending_pixels.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_pixels.size()));

        $display("Run covered %0d pixel writes, %0d filter requests, %0d register writes",
                 n_writes, n_requests, n_cfg_writes);
        $display("%0d results checked (%0d outside the image), three stall profiles, %0d errors",
                 n_results, n_oor, err_cnt);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
